### src/psn_pkg.sv
// Shared constants for the point set normalizer.
`default_nettype none
package psn_pkg;
  localparam int MAX_POINTS = 64;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int DIV_W      = 41;
  localparam int SQ_STEPS   = 33;
  localparam logic [DIV_W-1:0] SQRT2_Q32 = 41'd6074001000;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
endpackage
`default_nettype wire

### src/psn_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module psn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### src/point_set_normalizer.sv
// Point set normalizer: centroid, mean distance, scale and normalized points.
// Load: one point per cycle while in_tready is high (state S_LOAD). Closing a
// set of n points then runs the two centroid divisions, a distance pass per
// point (bit-pair square root), the mean and scale divisions (the scale one is
// skipped when the mean is zero) and an emit pass per point. One shared divider, multiplier, root unit.
// Reset (rst_n low, synchronous) empties the set and the output register.
`default_nettype none
module point_set_normalizer
  import psn_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [63:0]  in_tdata,   // x_coord[31:0], y_coord[63:32]
  input  wire logic         in_tlast,   // last_point
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // norm_x[31:0], norm_y[63:32], centroid_x[95:64], centroid_y[127:96], scale[159:128]
  output logic      [159:0] out_tdata,
  output logic              out_tlast   // last_out
);
  localparam logic [3:0] S_LOAD = 4'd0, S_DIVX = 4'd1, S_DIVY = 4'd2, S_DRD = 4'd3,
                         S_DDX  = 4'd4, S_DSQA = 4'd5, S_DSQB = 4'd6, S_DSQC = 4'd7,
                         S_SQRT = 4'd8, S_DIVM = 4'd9, S_DIVS = 4'd10, S_ERD = 4'd11,
                         S_EDX  = 4'd12, S_EMX = 4'd13, S_EMY = 4'd14, S_EFIN = 4'd15;

  logic [3:0]        st_r, st_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, n_r, n_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [37:0]       sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [39:0]       dsum_r, dsum_nxt;
  logic [31:0]       cx_r, cx_nxt, cy_r, cy_nxt, scale_r, scale_nxt;
  logic [32:0]       ax_r, ax_nxt, ay_r, ay_nxt;
  logic              sx_r, sx_nxt, sy_r, sy_nxt;
  logic [65:0]       mul_r, mul_nxt;
  logic [65:0]       rad_r, rad_nxt;
  logic [34:0]       sq_rem_r, sq_rem_nxt;
  logic [32:0]       sq_root_r, sq_root_nxt;
  logic [5:0]        sq_cnt_r, sq_cnt_nxt;
  logic [DIV_W-1:0]  dv_rem_r, dv_rem_nxt, dv_quo_r, dv_quo_nxt;
  logic [DIV_W-2:0]  dv_den_r, dv_den_nxt;
  logic [5:0]        dv_cnt_r, dv_cnt_nxt;
  logic [31:0]       nx_r, nx_nxt;
  logic              ov_r, ov_nxt, ol_r, ol_nxt;
  logic [159:0]      od_r, od_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [63:0]       ram_q;

  // shared datapath pieces
  logic [32:0]      mul_a, mul_b;
  logic [65:0]      mul_p;
  logic [DIV_W-1:0] dv_shift, dv_diff;
  logic             dv_ge;
  logic [34:0]      sq_shift, sq_trial;
  logic             sq_ge;
  logic [32:0]      dx, dy;
  logic [37:0]      smag;
  logic [48:0]      rq;
  logic [31:0]      sat_v;
  logic             sat_neg;
  logic [5:0]       half_n;
  logic             accept, close_set, out_free;

  psn_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata),
    .rdata (ram_q)
  );

  assign in_tready  = (st_r == S_LOAD);
  assign accept     = in_tvalid && in_tready;
  assign close_set  = in_tlast || (cnt_r == CNT_W'(MAX_POINTS - 1));
  assign ram_we     = accept;
  assign ram_addr   = (st_r == S_LOAD) ? cnt_r[ADDR_W-1:0] : idx_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_free   = !ov_r || out_tready;
  assign half_n     = n_r[CNT_W-1:1];

  assign mul_p    = mul_a * mul_b;
  assign dv_shift = {dv_rem_r[DIV_W-2:0], dv_quo_r[DIV_W-1]};
  assign dv_ge    = dv_shift >= {1'b0, dv_den_r};
  assign dv_diff  = dv_shift - {1'b0, dv_den_r};
  assign sq_shift = {sq_rem_r[32:0], rad_r[65:64]};
  assign sq_trial = {sq_root_r, 2'b01};
  assign sq_ge    = sq_shift >= sq_trial;
  assign dx = {ram_q[31], ram_q[31:0]} - {cx_r[31], cx_r};
  assign dy = {ram_q[63], ram_q[63:32]} - {cy_r[31], cy_r};

  always_comb begin
    unique case (st_r)
      S_DSQA:  begin mul_a = ax_r; mul_b = ax_r;              end
      S_DSQB:  begin mul_a = ay_r; mul_b = ay_r;              end
      S_EMX:   begin mul_a = ax_r; mul_b = {1'b0, scale_r};   end
      default: begin mul_a = ay_r; mul_b = {1'b0, scale_r};   end
    endcase
  end

  // round, apply sign, saturate the product held in mul_r
  always_comb begin
    sat_neg = (st_r == S_EMY) ? sx_r : sy_r;
    rq      = 49'(mul_r[63:16]) + 49'(mul_r[15]);
    if (sat_neg) begin
      sat_v = (rq > 49'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - rq[31:0]);
    end else begin
      sat_v = (rq > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : rq[31:0];
    end
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; n_nxt = n_r; idx_nxt = idx_r;
    sum_x_nxt = sum_x_r; sum_y_nxt = sum_y_r; dsum_nxt = dsum_r;
    cx_nxt = cx_r; cy_nxt = cy_r; scale_nxt = scale_r;
    ax_nxt = ax_r; ay_nxt = ay_r; sx_nxt = sx_r; sy_nxt = sy_r;
    mul_nxt = mul_r; rad_nxt = rad_r;
    sq_rem_nxt = sq_rem_r; sq_root_nxt = sq_root_r; sq_cnt_nxt = sq_cnt_r;
    dv_rem_nxt = dv_rem_r; dv_quo_nxt = dv_quo_r; dv_den_nxt = dv_den_r;
    dv_cnt_nxt = dv_cnt_r;
    nx_nxt = nx_r; ov_nxt = ov_r; ol_nxt = ol_r; od_nxt = od_r;
    smag = '0;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    // advance the divider one quotient bit
    if (dv_cnt_r != '0) begin
      dv_rem_nxt = dv_ge ? dv_diff : dv_shift;
      dv_quo_nxt = {dv_quo_r[DIV_W-2:0], dv_ge};
      dv_cnt_nxt = dv_cnt_r - 6'd1;
    end

    unique case (st_r)
      S_LOAD: begin
        if (accept) begin
          sum_x_nxt = sum_x_r + {{6{in_tdata[31]}}, in_tdata[31:0]};
          sum_y_nxt = sum_y_r + {{6{in_tdata[63]}}, in_tdata[63:32]};
          cnt_nxt   = cnt_r + 1'b1;
          if (close_set) begin
            n_nxt      = cnt_r + 1'b1;
            smag       = sum_x_nxt[37] ? (38'd0 - sum_x_nxt) : sum_x_nxt;
            dv_quo_nxt = DIV_W'(smag) + DIV_W'(cnt_nxt[CNT_W-1:1]);
            dv_den_nxt = (DIV_W-1)'(cnt_nxt);
            dv_rem_nxt = '0;
            dv_cnt_nxt = 6'(DIV_W);
            st_nxt     = S_DIVX;
          end
        end
      end
      S_DIVX: begin
        if (dv_cnt_r == '0) begin
          cx_nxt     = sum_x_r[37] ? (32'd0 - dv_quo_r[31:0]) : dv_quo_r[31:0];
          smag       = sum_y_r[37] ? (38'd0 - sum_y_r) : sum_y_r;
          dv_quo_nxt = DIV_W'(smag) + DIV_W'(half_n);
          dv_rem_nxt = '0;
          dv_cnt_nxt = 6'(DIV_W);
          st_nxt     = S_DIVY;
        end
      end
      S_DIVY: begin
        if (dv_cnt_r == '0) begin
          cy_nxt   = sum_y_r[37] ? (32'd0 - dv_quo_r[31:0]) : dv_quo_r[31:0];
          idx_nxt  = '0;
          dsum_nxt = '0;
          st_nxt   = S_DRD;
        end
      end
      S_DRD: st_nxt = S_DDX;
      S_DDX: begin
        ax_nxt = dx[32] ? (33'd0 - dx) : dx;
        ay_nxt = dy[32] ? (33'd0 - dy) : dy;
        st_nxt = S_DSQA;
      end
      S_DSQA: begin
        mul_nxt = mul_p;
        st_nxt  = S_DSQB;
      end
      S_DSQB: begin
        rad_nxt = mul_r;
        mul_nxt = mul_p;
        st_nxt  = S_DSQC;
      end
      S_DSQC: begin
        rad_nxt     = rad_r + mul_r;
        sq_rem_nxt  = '0;
        sq_root_nxt = '0;
        sq_cnt_nxt  = 6'(SQ_STEPS);
        st_nxt      = S_SQRT;
      end
      S_SQRT: begin
        if (sq_cnt_r != '0) begin
          sq_rem_nxt  = sq_ge ? (sq_shift - sq_trial) : sq_shift;
          sq_root_nxt = {sq_root_r[31:0], sq_ge};
          rad_nxt     = {rad_r[63:0], 2'b00};
          sq_cnt_nxt  = sq_cnt_r - 6'd1;
        end else begin
          dsum_nxt = dsum_r + 40'(sq_root_r);
          if (CNT_W'(idx_r) == n_r - 1'b1) begin
            dv_quo_nxt = DIV_W'(dsum_nxt) + DIV_W'(half_n);
            dv_den_nxt = (DIV_W-1)'(n_r);
            dv_rem_nxt = '0;
            dv_cnt_nxt = 6'(DIV_W);
            st_nxt     = S_DIVM;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt  = S_DRD;
          end
        end
      end
      S_DIVM: begin
        if (dv_cnt_r == '0) begin
          idx_nxt = '0;
          if (dv_quo_r == '0) begin
            scale_nxt = ONE_Q16;
            st_nxt    = S_ERD;
          end else begin
            dv_den_nxt = dv_quo_r[DIV_W-2:0];
            dv_quo_nxt = SQRT2_Q32 + (dv_quo_r >> 1);
            dv_rem_nxt = '0;
            dv_cnt_nxt = 6'(DIV_W);
            st_nxt     = S_DIVS;
          end
        end
      end
      S_DIVS: begin
        if (dv_cnt_r == '0) begin
          scale_nxt = (dv_quo_r[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : dv_quo_r[31:0];
          st_nxt    = S_ERD;
        end
      end
      S_ERD: st_nxt = S_EDX;
      S_EDX: begin
        ax_nxt = dx[32] ? (33'd0 - dx) : dx;
        ay_nxt = dy[32] ? (33'd0 - dy) : dy;
        sx_nxt = dx[32];
        sy_nxt = dy[32];
        st_nxt = S_EMX;
      end
      S_EMX: begin
        mul_nxt = mul_p;
        st_nxt  = S_EMY;
      end
      S_EMY: begin
        nx_nxt  = sat_v;
        mul_nxt = mul_p;
        st_nxt  = S_EFIN;
      end
      S_EFIN: begin
        // hold until the output register is free
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = {scale_r, cy_r, cx_r, sat_v, nx_r};
          ol_nxt = (CNT_W'(idx_r) == n_r - 1'b1);
          if (ol_nxt) begin
            cnt_nxt   = '0;
            sum_x_nxt = '0;
            sum_y_nxt = '0;
            st_nxt    = S_LOAD;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt  = S_ERD;
          end
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_LOAD;
      cnt_r    <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      dv_cnt_r <= '0;
      sq_cnt_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      cnt_r    <= cnt_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      dv_cnt_r <= dv_cnt_nxt;
      sq_cnt_r <= sq_cnt_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt; idx_r <= idx_nxt; dsum_r <= dsum_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; scale_r <= scale_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; sx_r <= sx_nxt; sy_r <= sy_nxt;
    mul_r <= mul_nxt; rad_r <= rad_nxt;
    sq_rem_r <= sq_rem_nxt; sq_root_r <= sq_root_nxt;
    dv_rem_r <= dv_rem_nxt; dv_quo_r <= dv_quo_nxt; dv_den_r <= dv_den_nxt;
    nx_r <= nx_nxt; ol_r <= ol_nxt; od_r <= od_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_LOAD) |-> (cnt_r < CNT_W'(MAX_POINTS))) else $error("point count out of range");
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (st_r == S_DIVX)) else $error("set not closed");
  a_scale_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[159:128] != 32'd0)) else $error("zero scale");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EFIN) |-> (CNT_W'(idx_r) < n_r)) else $error("emit index past set");
endmodule
`default_nettype wire
